/* src/pdgc_pkg.sv */
// pdgc_pkg: shared types and constants of the poisson disk grid check unit
// no dependencies; imported by the top level, the checker and the bench
`default_nettype none

package pdgc_pkg;

    // sequencer states of the top level
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_LIMIT,
        ST_CHECK,
        ST_OWN_READ,
        ST_OWN_CHK,
        ST_NB_SEL,
        ST_NB_READ,
        ST_NB_DX,
        ST_NB_DY,
        ST_NB_CMP,
        ST_WRITE,
        ST_FINISH
    } state_t;

    // result status codes
    localparam int STATUS_W = 3;
    localparam logic [STATUS_W-1:0] STATUS_STORED       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_MARGIN       = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_OCCUPIED     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_TOO_CLOSE    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE_GRID = 3'd4;

    // operation codes
    localparam logic OP_VERIFY = 1'b0;
    localparam logic OP_SEED   = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd5;

    // reset values of the configuration registers
    localparam int RST_AREA_WIDTH   = 16384;
    localparam int RST_AREA_HEIGHT  = 16384;
    localparam int RST_MIN_DISTANCE = 362;
    localparam int RST_CELL_SIZE    = 256;
    localparam int RST_GRID_COLS    = 64;
    localparam int RST_GRID_ROWS    = 64;

    // grid size registers and result cell fields
    localparam int GRID_REG_W   = 7;
    localparam int CELL_FIELD_W = 6;
    localparam logic [CELL_FIELD_W-1:0] CELL_FIELD_MAX = 6'd63;

    // result channel packing
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 4;

    // neighborhood offsets, -2 .. 2
    localparam int OFS_W = 3;
    localparam logic signed [OFS_W-1:0] NEAR_LO = -3'sd2;
    localparam logic signed [OFS_W-1:0] NEAR_HI = 3'sd2;

endpackage

`default_nettype wire

/* src/pdgc_ram.sv */
// pdgc_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module pdgc_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/pdgc_div.sv */
// pdgc_div: restoring divider, one quotient bit per cycle
// no dependencies; shared by both cell index divisions
`default_nettype none

module pdgc_div #(
    parameter int W = 20
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic      [W-1:0] quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       shifted;
    logic [W:0]       trial;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, divisor};
    // a zero divisor always fits, so the quotient comes out all ones
    assign fits    = (shifted >= {1'b0, divisor});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? trial[W-1:0] : shifted[W-1:0];
            quo_next  = {quo_reg[W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* src/pdgc_sqdiff.sv */
// pdgc_sqdiff: squared absolute difference with a registered product
// no dependencies; shared by the limit and all neighbor distance terms
`default_nettype none

module pdgc_sqdiff #(
    parameter int W = 20
) (
    input  wire logic           aclk,
    input  wire logic [W-1:0]   a,
    input  wire logic [W-1:0]   b,
    output logic      [2*W-1:0] sq
);

    logic [W-1:0] diff;

    assign diff = (a > b) ? (a - b) : (b - a);

    always_ff @(posedge aclk) begin
        sq <= (2*W)'(diff) * (2*W)'(diff);
    end

endmodule

`default_nettype wire

/* src/poisson_disk_grid_check_unit.sv */
// poisson_disk_grid_check_unit: candidate acceptance test of a poisson disk sampler
// depends on pdgc_pkg, pdgc_ram, pdgc_div, pdgc_sqdiff
// an item runs two serial divisions; a verify also checks its own cell and each stored neighbor
// one item at a time; the input is ready again in the cycle after the result is loaded
// reset: synchronous active low, then a clearing pass that writes zero to all
//   MAX_ROWS*2**clog2(MAX_COLS) store entries
`default_nettype none

module poisson_disk_grid_check_unit #(
    parameter int MAX_COLS   = 64,
    parameter int MAX_ROWS   = 64,
    parameter int COORD_BITS = 20,
    localparam int S_TDATA_W = ((2*COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // point_x, point_y, zero fill
    input  wire logic                  s_tuser,   // operation
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [pdgc_pkg::M_TDATA_W-1:0] m_tdata, // cell_col, cell_row, zero fill
    output logic [pdgc_pkg::M_TUSER_W-1:0] m_tuser, // accepted, status
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [pdgc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_BITS-1:0] cfg_wdata
);

    import pdgc_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int CW     = $clog2(MAX_COLS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int AW     = RW + CW;
    localparam int DEPTH  = MAX_ROWS << CW;
    localparam int ENT_W  = 2*CB + 1;
    localparam int SQ_W   = 2*CB;

    // configuration registers
    logic [CB-1:0]         area_width_reg;
    logic [CB-1:0]         area_height_reg;
    logic [CB-1:0]         min_distance_reg;
    logic [CB-1:0]         cell_size_reg;
    logic [GRID_REG_W-1:0] grid_cols_reg;
    logic [GRID_REG_W-1:0] grid_rows_reg;

    // sequencer and item registers
    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic                   op_reg, op_next;
    logic [CB-1:0]          px_reg, px_next;
    logic [CB-1:0]          py_reg, py_next;
    logic [CB-1:0]          col_q_reg, col_q_next;
    logic [CB-1:0]          row_q_reg, row_q_next;
    logic [SQ_W-1:0]        limit_reg, limit_next;
    logic [SQ_W-1:0]        sqa_reg, sqa_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic signed [OFS_W-1:0] dr_reg, dr_next;
    logic signed [OFS_W-1:0] dc_reg, dc_next;
    logic [CW-1:0]          nb_c_reg, nb_c_next;
    logic [RW-1:0]          nb_r_reg, nb_r_next;

    // result registers
    logic                    m_tvalid_reg, m_tvalid_next;
    logic                    m_accepted_reg, m_accepted_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;
    logic [CELL_FIELD_W-1:0] m_col_reg, m_col_next;
    logic [CELL_FIELD_W-1:0] m_row_reg, m_row_next;

    // shared units
    logic            div_start;
    logic [CB-1:0]   div_dividend;
    logic            div_done;
    logic [CB-1:0]   div_quotient;
    logic [CB-1:0]   sq_a;
    logic [CB-1:0]   sq_b;
    logic [SQ_W-1:0] sq_out;

    // cell store
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [ENT_W-1:0] ram_rdata;
    logic             rd_valid;
    logic [CB-1:0]    rd_x;
    logic [CB-1:0]    rd_y;

    // decisions
    logic                  in_xfer;
    logic                  out_free;
    logic [GRID_REG_W-1:0] cols_eff;
    logic [GRID_REG_W-1:0] rows_eff;
    logic                  margin_ok;
    logic                  in_grid;
    logic [CW-1:0]         col_idx;
    logic [RW-1:0]         row_idx;
    logic signed [CW+1:0]  c_sum;
    logic signed [RW+1:0]  r_sum;
    logic                  nb_in_range;
    logic                  nb_last;
    logic [SQ_W:0]         dist_sum;
    logic                  too_close;
    logic                  advance;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign cols_eff = (32'(grid_cols_reg) < 32'(MAX_COLS)) ? grid_cols_reg
                                                           : GRID_REG_W'(MAX_COLS);
    assign rows_eff = (32'(grid_rows_reg) < 32'(MAX_ROWS)) ? grid_rows_reg
                                                           : GRID_REG_W'(MAX_ROWS);

    assign margin_ok = (min_distance_reg <= px_reg)
                    && (({1'b0, px_reg} + {1'b0, min_distance_reg}) <= {1'b0, area_width_reg})
                    && (min_distance_reg <= py_reg)
                    && (({1'b0, py_reg} + {1'b0, min_distance_reg}) <= {1'b0, area_height_reg});
    assign in_grid   = (col_q_reg < CB'(cols_eff)) && (row_q_reg < CB'(rows_eff));

    assign col_idx = CW'(col_q_reg);
    assign row_idx = RW'(row_q_reg);

    // neighbor cell for the current offsets and whether it lies inside the grid
    assign c_sum = $signed({2'b00, col_idx}) + (CW+2)'(dc_reg);
    assign r_sum = $signed({2'b00, row_idx}) + (RW+2)'(dr_reg);
    assign nb_in_range = !c_sum[CW+1] && !r_sum[RW+1]
                      && (32'(c_sum[CW:0]) < 32'(cols_eff))
                      && (32'(r_sum[RW:0]) < 32'(rows_eff));
    assign nb_last = (dr_reg == NEAR_HI) && (dc_reg == NEAR_HI);

    assign rd_valid = ram_rdata[0];
    assign rd_x     = ram_rdata[CB:1];
    assign rd_y     = ram_rdata[2*CB:CB+1];

    // dx^2 waits in sqa_reg, dy^2 is on the squarer output
    assign dist_sum  = {1'b0, sqa_reg} + {1'b0, sq_out};
    assign too_close = dist_sum < {1'b0, limit_reg};

    assign advance = ((state_reg == ST_NB_SEL) && !nb_in_range)
                  || ((state_reg == ST_NB_DX) && !rd_valid)
                  || ((state_reg == ST_NB_CMP) && !too_close);

    pdgc_div #(.W(CB)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cell_size_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    pdgc_sqdiff #(.W(CB)) u_sq (
        .aclk (aclk),
        .a    (sq_a),
        .b    (sq_b),
        .sq   (sq_out)
    );

    pdgc_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr ({nb_r_reg, nb_c_reg}),
        .rdata (ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DIV_X;
            end
            ST_DIV_X: begin
                if (div_done) state_next = ST_DIV_Y;
            end
            ST_DIV_Y: begin
                if (div_done) state_next = ST_LIMIT;
            end
            ST_LIMIT: state_next = ST_CHECK;
            ST_CHECK: begin
                if (op_reg == OP_VERIFY && !margin_ok) state_next = ST_FINISH;
                else if (!in_grid)                     state_next = ST_FINISH;
                else if (op_reg == OP_SEED)            state_next = ST_WRITE;
                else                                   state_next = ST_OWN_READ;
            end
            ST_OWN_READ: state_next = ST_OWN_CHK;
            ST_OWN_CHK: begin
                state_next = rd_valid ? ST_FINISH : ST_NB_SEL;
            end
            ST_NB_SEL: begin
                if (nb_in_range)  state_next = ST_NB_READ;
                else if (nb_last) state_next = ST_WRITE;
            end
            ST_NB_READ: state_next = ST_NB_DX;
            ST_NB_DX: begin
                if (rd_valid)     state_next = ST_NB_DY;
                else if (nb_last) state_next = ST_WRITE;
                else              state_next = ST_NB_SEL;
            end
            ST_NB_DY: state_next = ST_NB_CMP;
            ST_NB_CMP: begin
                if (too_close)    state_next = ST_FINISH;
                else if (nb_last) state_next = ST_WRITE;
                else              state_next = ST_NB_SEL;
            end
            ST_WRITE: state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // datapath and control outputs
    always_comb begin
        clr_cnt_next    = clr_cnt_reg;
        op_next         = op_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        col_q_next      = col_q_reg;
        row_q_next      = row_q_reg;
        limit_next      = limit_reg;
        sqa_next        = sqa_reg;
        status_next     = status_reg;
        dr_next         = dr_reg;
        dc_next         = dc_reg;
        nb_c_next       = nb_c_reg;
        nb_r_next       = nb_r_reg;
        m_accepted_next = m_accepted_reg;
        m_status_next   = m_status_reg;
        m_col_next      = m_col_reg;
        m_row_next      = m_row_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        div_start       = 1'b0;
        div_dividend    = py_reg;
        sq_a            = min_distance_reg;
        sq_b            = '0;
        ram_we          = 1'b0;
        ram_waddr       = {row_idx, col_idx};
        ram_wdata       = {py_reg, px_reg, 1'b1};

        case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    op_next      = s_tuser;
                    px_next      = s_tdata[CB-1:0];
                    py_next      = s_tdata[2*CB-1:CB];
                    div_start    = 1'b1;
                    div_dividend = s_tdata[CB-1:0];
                end
            end
            ST_DIV_X: begin
                if (div_done) begin
                    col_q_next = div_quotient;
                    div_start  = 1'b1;
                end
            end
            ST_DIV_Y: begin
                if (div_done) row_q_next = div_quotient;
            end
            ST_LIMIT: ;
            ST_CHECK: begin
                limit_next = sq_out;
                nb_c_next  = col_idx;
                nb_r_next  = row_idx;
                if (op_reg == OP_VERIFY && !margin_ok) status_next = STATUS_MARGIN;
                else if (!in_grid)                     status_next = STATUS_OUTSIDE_GRID;
            end
            ST_OWN_READ: ;
            ST_OWN_CHK: begin
                dr_next = NEAR_LO;
                dc_next = NEAR_LO;
                if (rd_valid) status_next = STATUS_OCCUPIED;
            end
            ST_NB_SEL: begin
                if (nb_in_range) begin
                    nb_c_next = CW'(c_sum);
                    nb_r_next = RW'(r_sum);
                end
            end
            ST_NB_READ: ;
            ST_NB_DX: begin
                sq_a = rd_x;
                sq_b = px_reg;
            end
            ST_NB_DY: begin
                sqa_next = sq_out;
                sq_a     = rd_y;
                sq_b     = py_reg;
            end
            ST_NB_CMP: begin
                if (too_close) status_next = STATUS_TOO_CLOSE;
            end
            ST_WRITE: begin
                ram_we      = 1'b1;
                status_next = STATUS_STORED;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    m_accepted_next = (status_reg == STATUS_STORED);
                    m_status_next   = status_reg;
                    m_col_next      = (col_q_reg > CB'(CELL_FIELD_MAX))
                                      ? CELL_FIELD_MAX : col_q_reg[CELL_FIELD_W-1:0];
                    m_row_next      = (row_q_reg > CB'(CELL_FIELD_MAX))
                                      ? CELL_FIELD_MAX : row_q_reg[CELL_FIELD_W-1:0];
                end
            end
            default: ;
        endcase

        // walk the 5x5 neighborhood row by row
        if (advance) begin
            if (dc_reg == NEAR_HI) begin
                dc_next = NEAR_LO;
                dr_next = dr_reg + 1'b1;
            end else begin
                dc_next = dc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
            area_width_reg   <= CB'(RST_AREA_WIDTH);
            area_height_reg  <= CB'(RST_AREA_HEIGHT);
            min_distance_reg <= CB'(RST_MIN_DISTANCE);
            cell_size_reg    <= CB'(RST_CELL_SIZE);
            grid_cols_reg    <= GRID_REG_W'(RST_GRID_COLS);
            grid_rows_reg    <= GRID_REG_W'(RST_GRID_ROWS);
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_AREA_WIDTH:   area_width_reg   <= cfg_wdata;
                    CFG_AREA_HEIGHT:  area_height_reg  <= cfg_wdata;
                    CFG_MIN_DISTANCE: min_distance_reg <= cfg_wdata;
                    CFG_CELL_SIZE:    cell_size_reg    <= cfg_wdata;
                    CFG_GRID_COLS:    grid_cols_reg    <= cfg_wdata[GRID_REG_W-1:0];
                    CFG_GRID_ROWS:    grid_rows_reg    <= cfg_wdata[GRID_REG_W-1:0];
                    default: ;
                endcase
            end
        end
        op_reg         <= op_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        col_q_reg      <= col_q_next;
        row_q_reg      <= row_q_next;
        limit_reg      <= limit_next;
        sqa_reg        <= sqa_next;
        status_reg     <= status_next;
        dr_reg         <= dr_next;
        dc_reg         <= dc_next;
        nb_c_reg       <= nb_c_next;
        nb_r_reg       <= nb_r_next;
        m_accepted_reg <= m_accepted_next;
        m_status_reg   <= m_status_next;
        m_col_reg      <= m_col_next;
        m_row_reg      <= m_row_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - 2*CELL_FIELD_W)'(0), m_row_reg, m_col_reg};
    assign m_tuser  = {m_status_reg, m_accepted_reg};

endmodule

`default_nettype wire

/* src/pdgc_checker.sv */
// pdgc_checker: port level assertions of the poisson disk grid check unit
// depends on pdgc_pkg; bound to poisson_disk_grid_check_unit below
`default_nettype none

module pdgc_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [pdgc_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [pdgc_pkg::M_TUSER_W-1:0] m_tuser
);

    import pdgc_pkg::*;

    // the clearing pass keeps the input closed right after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    // one item in flight: ready drops after an input transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in flight");

    // accepted flag agrees with the status code
    a_accepted_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == (m_tuser[STATUS_W:1] == STATUS_STORED)))
        else $error("accepted flag disagrees with status");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind poisson_disk_grid_check_unit pdgc_checker u_pdgc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* bench/poisson_disk_grid_check_unit_test.sv */
// self-checking bench for poisson_disk_grid_check_unit: directed table, then random candidates
// under several grid settings, each checked against its typed verdict or an in-bench predictor
// depends on pdgc_pkg and poisson_disk_grid_check_unit
`default_nettype none

module poisson_disk_grid_check_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pdgc_pkg::*;

    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 64;
    localparam int COORD_BITS  = 20;
    localparam int S_TDATA_W   = ((2*COORD_BITS + 7) / 8) * 8;
    localparam int MAX_CELLS   = MAX_COLS * MAX_ROWS;
    localparam int CLK_PERIOD  = 8;
    localparam int TAIL_CYCLES = 400;
    localparam int LIMIT_CYCLES = 2_500_000;
    localparam int N_DIRECTED  = 17;

    // indexes past the last register, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic                    accepted;
        logic [STATUS_W-1:0]     status;
        logic [CELL_FIELD_W-1:0] col;
        logic [CELL_FIELD_W-1:0] row;
    } grid_verdict_t;

    typedef struct {
        logic          op;
        coord_t        x;
        coord_t        y;
        bit            known;
        grid_verdict_t verdict;
    } point_case_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    coord_t               cfg_wdata = '0;

    // mirror of the block: settings and the cell store
    coord_t                area_w_q;
    coord_t                area_h_q;
    coord_t                min_dist_q;
    coord_t                cell_size_q;
    logic [GRID_REG_W-1:0] grid_cols_q;
    logic [GRID_REG_W-1:0] grid_rows_q;
    bit                    cell_used [MAX_CELLS];
    coord_t                cell_x [MAX_CELLS];
    coord_t                cell_y [MAX_CELLS];

    grid_verdict_t pending_verdicts [$];
    point_case_t   directed_cases [N_DIRECTED];
    int            mismatch_count = 0;
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;

    poisson_disk_grid_check_unit #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD/2) aclk = ~aclk;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // acceptance test of one candidate; updates the mirrored store
    function automatic grid_verdict_t predict_verdict(input logic op, input coord_t px,
                                                      input coord_t py);
        logic [63:0]   col, row, cols, rows, limit, dx, dy, ex, ey, md;
        logic [STATUS_W-1:0] st;
        bit            in_grid, margin_ok, close;
        int            r, c, idx;
        grid_verdict_t v;
        md  = 64'(min_dist_q);
        col = (cell_size_q == 0) ? '1 : 64'(px) / 64'(cell_size_q);
        row = (cell_size_q == 0) ? '1 : 64'(py) / 64'(cell_size_q);
        cols = (grid_cols_q < MAX_COLS) ? 64'(grid_cols_q) : 64'(MAX_COLS);
        rows = (grid_rows_q < MAX_ROWS) ? 64'(grid_rows_q) : 64'(MAX_ROWS);
        in_grid = (col < cols) && (row < rows);
        margin_ok = (md <= 64'(px)) && (64'(px) + md <= 64'(area_w_q)) &&
                    (md <= 64'(py)) && (64'(py) + md <= 64'(area_h_q));
        close = 1'b0;
        if (op == OP_VERIFY && in_grid) begin
            limit = md * md;
            for (int dr = -2; dr <= 2; dr++) begin
                for (int dc = -2; dc <= 2; dc++) begin
                    r = int'(row) + dr;
                    c = int'(col) + dc;
                    if (r >= 0 && c >= 0 && r < int'(rows) && c < int'(cols) &&
                        cell_used[r*MAX_COLS + c]) begin
                        ex = 64'(cell_x[r*MAX_COLS + c]);
                        ey = 64'(cell_y[r*MAX_COLS + c]);
                        dx = (ex > 64'(px)) ? ex - 64'(px) : 64'(px) - ex;
                        dy = (ey > 64'(py)) ? ey - 64'(py) : 64'(py) - ey;
                        if (dx*dx + dy*dy < limit)
                            close = 1'b1;
                    end
                end
            end
        end
        if (op == OP_VERIFY && !margin_ok)
            st = STATUS_MARGIN;
        else if (!in_grid)
            st = STATUS_OUTSIDE_GRID;
        else if (op == OP_VERIFY && cell_used[int'(row)*MAX_COLS + int'(col)])
            st = STATUS_OCCUPIED;
        else if (op == OP_VERIFY && close)
            st = STATUS_TOO_CLOSE;
        else
            st = STATUS_STORED;
        if (st == STATUS_STORED) begin
            idx = int'(row)*MAX_COLS + int'(col);
            cell_used[idx] = 1'b1;
            cell_x[idx] = px;
            cell_y[idx] = py;
        end
        v.accepted = (st == STATUS_STORED);
        v.status   = st;
        v.col      = (col > 64'(CELL_FIELD_MAX)) ? CELL_FIELD_MAX : col[CELL_FIELD_W-1:0];
        v.row      = (row > 64'(CELL_FIELD_MAX)) ? CELL_FIELD_MAX : row[CELL_FIELD_W-1:0];
        return v;
    endfunction

    // called at a rising edge, returns at the edge of the transfer
    task automatic send_point(input logic op, input coord_t px, input coord_t py,
                              input bit known, input grid_verdict_t typed);
        grid_verdict_t v;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({py, px});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        v = predict_verdict(op, px, py);
        if (known)
            v = typed;
        pending_verdicts = {pending_verdicts, v};
    endtask

    // hold off the sender until every verdict is back
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // leaves cfg_we high; the caller lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_AREA_WIDTH:   area_w_q    = val;
            CFG_AREA_HEIGHT:  area_h_q    = val;
            CFG_MIN_DISTANCE: min_dist_q  = val;
            CFG_CELL_SIZE:    cell_size_q = val;
            CFG_GRID_COLS:    grid_cols_q = val[GRID_REG_W-1:0];
            CFG_GRID_ROWS:    grid_rows_q = val[GRID_REG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input coord_t aw, input coord_t ah, input coord_t md,
                                input coord_t cs, input coord_t cols, input coord_t rows);
        write_reg(CFG_AREA_WIDTH, aw);
        write_reg(CFG_AREA_HEIGHT, ah);
        write_reg(CFG_MIN_DISTANCE, md);
        write_reg(CFG_CELL_SIZE, cs);
        write_reg(CFG_GRID_COLS, cols);
        write_reg(CFG_GRID_ROWS, rows);
        write_reg(CFG_SPARE_LO, coord_t'($urandom()));
        write_reg(CFG_SPARE_HI, coord_t'($urandom()));
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly points inside the area, some on the margin edges, some anywhere
    function automatic coord_t pick_coord(input coord_t extent);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 20)
            return coord_t'($urandom());
        if (sel < 32) begin
            case ($urandom_range(0, 3))
                0: return min_dist_q;
                1: return min_dist_q - 1'b1;
                2: return extent - min_dist_q;
                default: return extent - min_dist_q + 1'b1;
            endcase
        end
        return coord_t'($urandom_range(0, int'(extent)));
    endfunction

    task automatic scatter_points(input int count);
        logic   op;
        coord_t px, py;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(0, 99) < 12) ? OP_SEED : OP_VERIFY;
            px = pick_coord(area_w_q);
            py = pick_coord(area_h_q);
            send_point(op, px, py, 1'b0, '0);
        end
    endtask

    always @(posedge aclk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge aclk) begin
        grid_verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("verdict with no pending candidate", 32'(m_tdata), 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tuser[0] !== want.accepted)
                    report_mismatch("accepted", 32'(m_tuser[0]), 32'(want.accepted));
                if (m_tuser[3:1] !== want.status)
                    report_mismatch("status", 32'(m_tuser[3:1]), 32'(want.status));
                if (m_tdata[5:0] !== want.col)
                    report_mismatch("cell_col", 32'(m_tdata[5:0]), 32'(want.col));
                if (m_tdata[11:6] !== want.row)
                    report_mismatch("cell_row", 32'(m_tdata[11:6]), 32'(want.row));
            end
        end
    end

    initial begin
        area_w_q    = coord_t'(RST_AREA_WIDTH);
        area_h_q    = coord_t'(RST_AREA_HEIGHT);
        min_dist_q  = coord_t'(RST_MIN_DISTANCE);
        cell_size_q = coord_t'(RST_CELL_SIZE);
        grid_cols_q = GRID_REG_W'(RST_GRID_COLS);
        grid_rows_q = GRID_REG_W'(RST_GRID_ROWS);

        // reset settings, empty store; known rows are margin failures, grid edges or plain seeds
        directed_cases[0]  = '{OP_VERIFY, 20'd0, 20'd0, 1'b1, '{1'b0, STATUS_MARGIN, 6'd0, 6'd0}};
        directed_cases[1]  = '{OP_VERIFY, 20'hFFFFF, 20'hFFFFF, 1'b1,
                               '{1'b0, STATUS_MARGIN, 6'd63, 6'd63}};
        directed_cases[2]  = '{OP_SEED, 20'd0, 20'd0, 1'b1, '{1'b1, STATUS_STORED, 6'd0, 6'd0}};
        directed_cases[3]  = '{OP_SEED, 20'hFFFFF, 20'hFFFFF, 1'b1,
                               '{1'b0, STATUS_OUTSIDE_GRID, 6'd63, 6'd63}};
        directed_cases[4]  = '{OP_SEED, 20'hFFFFF, 20'd0, 1'b1,
                               '{1'b0, STATUS_OUTSIDE_GRID, 6'd63, 6'd0}};
        directed_cases[5]  = '{OP_VERIFY, 20'd362, 20'd362, 1'b0, '0};
        directed_cases[6]  = '{OP_VERIFY, 20'd400, 20'd400, 1'b0, '0};
        directed_cases[7]  = '{OP_VERIFY, 20'd600, 20'd362, 1'b0, '0};
        directed_cases[8]  = '{OP_VERIFY, 20'd16022, 20'd16022, 1'b0, '0};
        directed_cases[9]  = '{OP_VERIFY, 20'd16023, 20'd1000, 1'b1,
                               '{1'b0, STATUS_MARGIN, 6'd62, 6'd3}};
        directed_cases[10] = '{OP_VERIFY, 20'd1000, 20'd16023, 1'b1,
                               '{1'b0, STATUS_MARGIN, 6'd3, 6'd62}};
        directed_cases[11] = '{OP_SEED, 20'd400, 20'd400, 1'b1, '{1'b1, STATUS_STORED, 6'd1, 6'd1}};
        directed_cases[12] = '{OP_SEED, 20'd16138, 20'd16138, 1'b1,
                               '{1'b1, STATUS_STORED, 6'd63, 6'd63}};
        directed_cases[13] = '{OP_VERIFY, 20'd5000, 20'd5000, 1'b0, '0};
        directed_cases[14] = '{OP_VERIFY, 20'd5100, 20'd5300, 1'b0, '0};
        // exactly min_distance away: not too close
        directed_cases[15] = '{OP_VERIFY, 20'd5000, 20'd5362, 1'b0, '0};
        directed_cases[16] = '{OP_VERIFY, 20'd361, 20'd5000, 1'b1,
                               '{1'b0, STATUS_MARGIN, 6'd1, 6'd19}};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 25;
        rx_idle_pct = 73;
        for (int i = 0; i < N_DIRECTED; i++)
            send_point(directed_cases[i].op, directed_cases[i].x, directed_cases[i].y,
                       directed_cases[i].known, directed_cases[i].verdict);
        scatter_points(233);

        // small grid that fills up fast
        drain();
        apply_config(20'd2048, 20'd2048, 20'd362, 20'd256, 20'd8, 20'd8);
        scatter_points(200);

        tx_idle_pct = 73;
        rx_idle_pct = 25;
        // one huge cell, smallest spacing
        drain();
        apply_config(20'hFFFFF, 20'hFFFFF, 20'd1, 20'hFFFFF, 20'd64, 20'd64);
        scatter_points(60);

        // zero cell size: every point off the grid
        drain();
        apply_config(20'd4096, 20'd4096, 20'd100, 20'd0, 20'd64, 20'd64);
        scatter_points(60);

        // column count masks to zero, row count keeps only its low bits
        drain();
        apply_config(20'd4096, 20'd4096, 20'd100, 20'd128, 20'h00080, 20'hFFF87);
        scatter_points(50);

        // grid sizes above the maximum clip to it
        drain();
        apply_config(20'd4200, 20'd4200, 20'd90, 20'd64, 20'd127, 20'd100);
        scatter_points(200);

        // margin wider than the area
        drain();
        apply_config(20'd1, 20'd1, 20'hFFFFF, 20'd256, 20'd64, 20'd64);
        scatter_points(50);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drain();
        apply_config(20'd3000, 20'd1500, 20'd300, 20'd212, 20'd20, 20'd10);
        scatter_points(200);

        // smallest everything, a single cell
        drain();
        apply_config(20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1);
        scatter_points(40);

        drain();
        apply_config(20'd16384, 20'd16384, 20'd500, 20'd354, 20'd64, 20'd64);
        scatter_points(240);

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
src/pdgc_pkg.sv
src/pdgc_ram.sv
src/pdgc_div.sv
src/pdgc_sqdiff.sv
src/poisson_disk_grid_check_unit.sv
src/pdgc_checker.sv
bench/poisson_disk_grid_check_unit_test.sv
